// ----- sv/bso_pkg.sv -----
// shared types for the box pair bounding sphere overlap test
`timescale 1ns / 1ps
`default_nettype none
package bso_pkg;

  localparam int unsigned NumAxes = 3;

  typedef struct packed {
    logic valid;
    logic empty;
  } ctl_t;

endpackage
`default_nettype wire

// ----- sv/bso_prep.sv -----
// front stages: corner sums and differences, magnitudes, squares, squared lengths
`timescale 1ns / 1ps
`default_nettype none
module bso_prep #(
  parameter int unsigned CoordBits = 24,
  localparam int unsigned SumBits = 2 * CoordBits + 6
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          en_i,
  input  wire                          valid_i,
  input  wire logic signed [CoordBits-1:0] a_min_i [bso_pkg::NumAxes],
  input  wire logic signed [CoordBits-1:0] a_max_i [bso_pkg::NumAxes],
  input  wire logic signed [CoordBits-1:0] b_min_i [bso_pkg::NumAxes],
  input  wire logic signed [CoordBits-1:0] b_max_i [bso_pkg::NumAxes],
  output bso_pkg::ctl_t                ctl_o,
  output logic [SumBits-1:0]           len_c_o,
  output logic [SumBits-1:0]           len_a_o,
  output logic [SumBits-1:0]           len_b_o
);

  localparam int unsigned W = CoordBits;

  bso_pkg::ctl_t ctl1_d, ctl1_q, ctl2_q, ctl3_q;
  logic [W+1:0]   mc_d [bso_pkg::NumAxes];
  logic [W:0]     ma_d [bso_pkg::NumAxes];
  logic [W:0]     mb_d [bso_pkg::NumAxes];
  logic [W+1:0]   mc_q [bso_pkg::NumAxes];
  logic [W:0]     ma_q [bso_pkg::NumAxes];
  logic [W:0]     mb_q [bso_pkg::NumAxes];
  logic [2*W+3:0] sc_q [bso_pkg::NumAxes];
  logic [2*W+1:0] sa_q [bso_pkg::NumAxes];
  logic [2*W+1:0] sb_q [bso_pkg::NumAxes];
  logic [SumBits-1:0] lc_q, la_q, lb_q;

  always_comb begin
    logic signed [W+2:0] cd;
    logic signed [W:0]   da;
    logic signed [W:0]   db;
    ctl1_d.valid = valid_i;
    ctl1_d.empty = 1'b1;
    for (int k = 0; k < bso_pkg::NumAxes; k++) begin
      cd = ({{3{a_max_i[k][W-1]}}, a_max_i[k]} + {{3{a_min_i[k][W-1]}}, a_min_i[k]})
         - ({{3{b_max_i[k][W-1]}}, b_max_i[k]} + {{3{b_min_i[k][W-1]}}, b_min_i[k]});
      da = {a_max_i[k][W-1], a_max_i[k]} - {a_min_i[k][W-1], a_min_i[k]};
      db = {b_max_i[k][W-1], b_max_i[k]} - {b_min_i[k][W-1], b_min_i[k]};
      mc_d[k] = cd[W+2] ? (W+2)'(0) - cd[W+1:0] : cd[W+1:0];
      ma_d[k] = da[W] ? (W+1)'(0) - da : da;
      mb_d[k] = db[W] ? (W+1)'(0) - db : db;
      if ((a_min_i[k] != '0) || (a_max_i[k] != '0)) begin
        ctl1_d.empty = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
      ctl3_q <= '0;
    end else if (en_i) begin
      ctl1_q <= ctl1_d;
      ctl2_q <= ctl1_q;
      ctl3_q <= ctl2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < bso_pkg::NumAxes; k++) begin
        mc_q[k] <= mc_d[k];
        ma_q[k] <= ma_d[k];
        mb_q[k] <= mb_d[k];
        sc_q[k] <= (2*W+4)'(mc_q[k]) * (2*W+4)'(mc_q[k]);
        sa_q[k] <= (2*W+2)'(ma_q[k]) * (2*W+2)'(ma_q[k]);
        sb_q[k] <= (2*W+2)'(mb_q[k]) * (2*W+2)'(mb_q[k]);
      end
      lc_q <= SumBits'(sc_q[0]) + SumBits'(sc_q[1]) + SumBits'(sc_q[2]);
      la_q <= SumBits'(sa_q[0]) + SumBits'(sa_q[1]) + SumBits'(sa_q[2]);
      lb_q <= SumBits'(sb_q[0]) + SumBits'(sb_q[1]) + SumBits'(sb_q[2]);
    end
  end

  assign ctl_o   = ctl3_q;
  assign len_c_o = lc_q;
  assign len_a_o = la_q;
  assign len_b_o = lb_q;

endmodule
`default_nettype wire

// ----- sv/bso_isqrt.sv -----
// pipelined integer square root, one result bit per stage
`timescale 1ns / 1ps
`default_nettype none
module bso_isqrt #(
  parameter int unsigned RootBits = 27
) (
  input  wire                      clk_i,
  input  wire                      en_i,
  input  wire [2*RootBits-1:0]     op_i,
  output logic [RootBits-1:0]      root_o
);

  localparam int unsigned RW = RootBits;

  logic [RW+1:0]   rem_q  [RW-1];
  logic [2*RW-1:0] op_q   [RW-1];
  logic [RW-1:0]   root_q [RW];

  for (genvar s = 0; s < RW; s++) begin : g_stage
    logic [RW+1:0]   rem_in;
    logic [RW-1:0]   root_in;
    logic [2*RW-1:0] op_in;
    logic [RW+3:0]   rem_cat;
    logic [RW+3:0]   trial;
    logic [RW+3:0]   diff;
    logic            take;

    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign op_in   = op_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign op_in   = op_q[s-1];
    end

    assign rem_cat = {rem_in, op_in[2*RW-1 -: 2]};
    assign trial   = {2'b00, root_in, 2'b01};
    assign diff    = rem_cat - trial;
    assign take    = rem_cat >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[s] <= {root_in[RW-2:0], take};
      end
    end

    if (s < RW - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s] <= take ? diff[RW+1:0] : rem_cat[RW+1:0];
          op_q[s]  <= {op_in[2*RW-3:0], 2'b00};
        end
      end
    end
  end

  assign root_o = root_q[RW-1];

endmodule
`default_nettype wire

// ----- sv/box_sphere_overlap_test.sv -----
// top level: bounding sphere overlap test of two axis-aligned boxes
//
//  channel | signals                              | direction
//  input   | in_valid_i, in_ready_o, a_*/b_*_i    | one box pair per item
//  output  | out_valid_o, out_ready_i, colliding_o | one flag per item
//
// pipeline: three front stages, one stage per root bit
// (COORD_BITS + 3) in the square root pipeline, one compare stage.
// one item per cycle is taken while the output register is empty or being read.
// a stall at the output freezes the whole pipeline; nothing is dropped or repeated.
// reset clears the control bits (valid and empty) only.
`timescale 1ns / 1ps
`default_nettype none
module box_sphere_overlap_test #(
  parameter int unsigned COORD_BITS = 24
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  output logic                          in_ready_o,
  input  wire logic signed [COORD_BITS-1:0] a_min_x_i,
  input  wire logic signed [COORD_BITS-1:0] a_min_y_i,
  input  wire logic signed [COORD_BITS-1:0] a_min_z_i,
  input  wire logic signed [COORD_BITS-1:0] a_max_x_i,
  input  wire logic signed [COORD_BITS-1:0] a_max_y_i,
  input  wire logic signed [COORD_BITS-1:0] a_max_z_i,
  input  wire logic signed [COORD_BITS-1:0] b_min_x_i,
  input  wire logic signed [COORD_BITS-1:0] b_min_y_i,
  input  wire logic signed [COORD_BITS-1:0] b_min_z_i,
  input  wire logic signed [COORD_BITS-1:0] b_max_x_i,
  input  wire logic signed [COORD_BITS-1:0] b_max_y_i,
  input  wire logic signed [COORD_BITS-1:0] b_max_z_i,
  output logic                          out_valid_o,
  input  wire                           out_ready_i,
  output logic                          colliding_o
);

  localparam int unsigned RW = COORD_BITS + 3;

  logic en;
  logic signed [COORD_BITS-1:0] a_min [bso_pkg::NumAxes];
  logic signed [COORD_BITS-1:0] a_max [bso_pkg::NumAxes];
  logic signed [COORD_BITS-1:0] b_min [bso_pkg::NumAxes];
  logic signed [COORD_BITS-1:0] b_max [bso_pkg::NumAxes];
  bso_pkg::ctl_t   prep_ctl;
  bso_pkg::ctl_t   ctl_q [RW];
  logic [2*RW-1:0] len_c, len_a, len_b;
  logic [RW-1:0]   dc, d1, d2;
  logic            hit;
  logic            out_valid_q, colliding_q;

  assign en = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  assign a_min = '{a_min_x_i, a_min_y_i, a_min_z_i};
  assign a_max = '{a_max_x_i, a_max_y_i, a_max_z_i};
  assign b_min = '{b_min_x_i, b_min_y_i, b_min_z_i};
  assign b_max = '{b_max_x_i, b_max_y_i, b_max_z_i};

  bso_prep #(.CoordBits(COORD_BITS)) u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .a_min_i (a_min),
    .a_max_i (a_max),
    .b_min_i (b_min),
    .b_max_i (b_max),
    .ctl_o   (prep_ctl),
    .len_c_o (len_c),
    .len_a_o (len_a),
    .len_b_o (len_b)
  );

  bso_isqrt #(.RootBits(RW)) u_sqrt_c (.clk_i(clk_i), .en_i(en), .op_i(len_c), .root_o(dc));
  bso_isqrt #(.RootBits(RW)) u_sqrt_a (.clk_i(clk_i), .en_i(en), .op_i(len_a), .root_o(d1));
  bso_isqrt #(.RootBits(RW)) u_sqrt_b (.clk_i(clk_i), .en_i(en), .op_i(len_b), .root_o(d2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < RW; s++) begin
        ctl_q[s] <= '0;
      end
    end else if (en) begin
      ctl_q[0] <= prep_ctl;
      for (int s = 1; s < RW; s++) begin
        ctl_q[s] <= ctl_q[s-1];
      end
    end
  end

  assign hit = !ctl_q[RW-1].empty &&
               ({1'b0, dc} <= ({1'b0, d1} + {1'b0, d2}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= ctl_q[RW-1].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      colliding_q <= hit;
    end
  end

  assign out_valid_o = out_valid_q;
  assign colliding_o = colliding_q;

  a_empty_no_hit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && ctl_q[RW-1].valid && ctl_q[RW-1].empty |=> !colliding_q)
    else $error("empty first box reported as colliding");

  a_far_no_hit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && ctl_q[RW-1].valid && ({1'b0, dc} > ({1'b0, d1} + {1'b0, d2}))
    |=> !colliding_q)
    else $error("separated spheres reported as colliding");

  a_stall_freeze : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(ctl_q[RW-1]) && $stable(prep_ctl))
    else $error("pipeline moved during a stall");

endmodule
`default_nettype wire
